/* rtl/sine_cosine_taylor_assert.svh */
// ----------------------------------------------------------------------------
// sine_cosine_taylor_assert.svh
// Assertion macros for the sine/cosine evaluator. Each macro expects clk and
// rst in scope and checks on the rising edge outside of reset.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_TAYLOR_ASSERT_SVH
`define SINE_COSINE_TAYLOR_ASSERT_SVH

// Condition that holds at every edge
`define SCT_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sine_cosine_taylor: invariant violated");

// Consequence in the same cycle
`define SCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sine_cosine_taylor: implication violated");

// Consequence in the next cycle
`define SCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sine_cosine_taylor: next-cycle check violated");

`endif

/* rtl/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and fixed-point constants of the sine/cosine evaluator.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Magnitudes in the polynomial are unsigned Q3.60 in 63 bits
  localparam int MAG_W     = 63;
  localparam int NUM_STEPS = 7;

  typedef logic [MAG_W-1:0] mag_t;

  // Item travelling down the polynomial pipeline
  typedef struct packed {
    logic vld;
    logic cos;    // 1: cosine, 0: sine
    logic neg;    // sign picked up by the symmetry folds
    mag_t x;      // reduced angle, Q3.60
    mag_t x2;     // x squared, Q3.60
    mag_t p;      // Horner accumulator magnitude
    logic p_neg;  // Horner accumulator sign
  } tok_t;

  // Finished result leaving the pipeline
  typedef struct packed {
    logic               vld;
    logic signed [31:0] value;
  } res_t;

  // Angle constants in units of 2^-57
  localparam logic [63:0] TAU_Q57     = 64'h0C90_FDAA_2216_8C23;
  localparam logic [63:0] PI_Q57      = 64'h0648_7ED5_110B_4611;
  localparam logic [63:0] HALF_PI_Q57 = 64'h0324_3F6A_8885_A308;

  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  localparam logic [63:0] FACT [16] = '{
    64'd1, 64'd1, 64'd2, 64'd6,
    64'd24, 64'd120, 64'd720, 64'd5040,
    64'd40320, 64'd362880, 64'd3628800, 64'd39916800,
    64'd479001600, 64'd6227020800, 64'd87178291200, 64'd1307674368000
  };

  // 1/n! in Q3.60, rounded to nearest
  localparam logic [63:0] INV_FACT [16] = '{
    (ONE_Q60 + FACT[0]  / 2) / FACT[0],
    (ONE_Q60 + FACT[1]  / 2) / FACT[1],
    (ONE_Q60 + FACT[2]  / 2) / FACT[2],
    (ONE_Q60 + FACT[3]  / 2) / FACT[3],
    (ONE_Q60 + FACT[4]  / 2) / FACT[4],
    (ONE_Q60 + FACT[5]  / 2) / FACT[5],
    (ONE_Q60 + FACT[6]  / 2) / FACT[6],
    (ONE_Q60 + FACT[7]  / 2) / FACT[7],
    (ONE_Q60 + FACT[8]  / 2) / FACT[8],
    (ONE_Q60 + FACT[9]  / 2) / FACT[9],
    (ONE_Q60 + FACT[10] / 2) / FACT[10],
    (ONE_Q60 + FACT[11] / 2) / FACT[11],
    (ONE_Q60 + FACT[12] / 2) / FACT[12],
    (ONE_Q60 + FACT[13] / 2) / FACT[13],
    (ONE_Q60 + FACT[14] / 2) / FACT[14],
    (ONE_Q60 + FACT[15] / 2) / FACT[15]
  };

endpackage

/* rtl/sct_reduce.sv */
// ----------------------------------------------------------------------------
// sct_reduce
// Range reduction: magnitude, modulo two pi by four compare-subtract stages,
// then the folds about pi and pi/2, seven register stages in all.
// ----------------------------------------------------------------------------
module sct_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic               mode,
  input  logic signed [31:0] angle,
  output sct_pkg::tok_t      tok_out
);

  typedef struct packed {
    logic        vld;
    logic        cos;
    logic        neg;
    logic [63:0] r;
  } red_t;

  red_t        st [6];
  logic [31:0] mag;
  logic [64:0] d_pi;
  logic [63:0] r_pi_next;
  logic [64:0] d_half;
  logic [63:0] r_half_next;

  // Take the magnitude; sine keeps the sign of the angle
  assign mag = angle[31] ? (32'd0 - $unsigned(angle)) : $unsigned(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (en) begin
      st[0].vld <= in_vld;
      st[0].cos <= mode;
      st[0].neg <= ~mode & angle[31];
      st[0].r   <= {mag, 32'd0};
    end
  end

  // Subtract 8, 4, 2 and 1 times two pi where it fits
  for (genvar g = 0; g < 4; g++) begin : g_mod
    localparam logic [63:0] STEP_M = sct_pkg::TAU_Q57 << (3 - g);
    logic [64:0] diff;

    assign diff = {1'b0, st[g].r} - {1'b0, STEP_M};

    always_ff @(posedge clk) begin
      if (rst) begin
        st[g+1].vld <= 1'b0;
      end else if (en) begin
        st[g+1].vld <= st[g].vld;
        st[g+1].cos <= st[g].cos;
        st[g+1].neg <= st[g].neg;
        st[g+1].r   <= diff[64] ? st[g].r : diff[63:0];
      end
    end
  end

  // Fold (pi, 2pi] back onto [0, pi); sine flips
  assign d_pi      = {1'b0, sct_pkg::PI_Q57} - {1'b0, st[4].r};
  assign r_pi_next = d_pi[64] ? (sct_pkg::TAU_Q57 - st[4].r) : st[4].r;

  always_ff @(posedge clk) begin
    if (rst) begin
      st[5].vld <= 1'b0;
    end else if (en) begin
      st[5].vld <= st[4].vld;
      st[5].cos <= st[4].cos;
      st[5].neg <= st[4].neg ^ (d_pi[64] & ~st[4].cos);
      st[5].r   <= r_pi_next;
    end
  end

  // Fold (pi/2, pi] back onto [0, pi/2); cosine flips
  assign d_half      = {1'b0, sct_pkg::HALF_PI_Q57} - {1'b0, st[5].r};
  assign r_half_next = d_half[64] ? (sct_pkg::PI_Q57 - st[5].r) : st[5].r;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok_out.vld   <= st[5].vld;
      tok_out.cos   <= st[5].cos;
      tok_out.neg   <= st[5].neg ^ (d_half[64] & st[5].cos);
      tok_out.x     <= {r_half_next[59:0], 3'b000};
      tok_out.x2    <= '0;
      tok_out.p     <= '0;
      tok_out.p_neg <= 1'b0;
    end
  end

endmodule

/* rtl/sct_mul.sv */
// ----------------------------------------------------------------------------
// sct_mul
// Three-stage Q3.60 magnitude multiplier: 32-bit partial products, middle
// sum, final add. Returns bits 122..60 of the exact product and carries the
// pipeline item alongside.
// ----------------------------------------------------------------------------
module sct_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  sct_pkg::tok_t tok_in,
  input  sct_pkg::mag_t a,
  input  sct_pkg::mag_t b,
  output sct_pkg::tok_t tok_out,
  output sct_pkg::mag_t prod
);

  sct_pkg::tok_t tok1;
  sct_pkg::tok_t tok2;
  logic [63:0]   pp00;
  logic [62:0]   pp01;
  logic [62:0]   pp10;
  logic [61:0]   pp11;
  logic [63:0]   q00;
  logic [61:0]   q11;
  logic [63:0]   mid;
  logic [125:0]  full;

  // Carry the item along
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1.vld    <= 1'b0;
      tok2.vld    <= 1'b0;
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok1    <= tok_in;
      tok2    <= tok1;
      tok_out <= tok2;
    end
  end

  // Partial products, middle sum, then the final add
  assign full = {q11, q00} + {30'd0, mid, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a[31:0]  * b[31:0];
      pp01 <= a[31:0]  * b[62:32];
      pp10 <= a[62:32] * b[31:0];
      pp11 <= a[62:32] * b[62:32];
      q00  <= pp00;
      q11  <= pp11;
      mid  <= {1'b0, pp01} + {1'b0, pp10};
      prod <= full[122:60];
    end
  end

endmodule

/* rtl/sct_horner.sv */
// ----------------------------------------------------------------------------
// sct_horner
// One Horner step, p = c - x2 * p, in sign-magnitude: a multiply followed by
// one subtract stage. The coefficient is picked by the item's mode.
// ----------------------------------------------------------------------------
module sct_horner (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  sct_pkg::tok_t tok_in,
  input  sct_pkg::mag_t coef_cos,
  input  sct_pkg::mag_t coef_sin,
  output sct_pkg::tok_t tok_out
);

  sct_pkg::tok_t tok_m;
  sct_pkg::tok_t tok_next;
  sct_pkg::mag_t q;
  sct_pkg::mag_t c;
  logic [63:0]   sum;
  logic [63:0]   dif;
  logic [63:0]   rdif;

  sct_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tok_in  (tok_in),
    .a       (tok_in.x2),
    .b       (tok_in.p),
    .tok_out (tok_m),
    .prod    (q)
  );

  // Product takes the sign of p; subtract it from the coefficient
  always_comb begin
    c        = tok_m.cos ? coef_cos : coef_sin;
    sum      = {1'b0, c} + {1'b0, q};
    dif      = {1'b0, c} - {1'b0, q};
    rdif     = {1'b0, q} - {1'b0, c};
    tok_next = tok_m;
    if (tok_m.p_neg) begin
      tok_next.p     = sum[62:0];
      tok_next.p_neg = 1'b0;
    end else if (dif[63]) begin
      tok_next.p     = rdif[62:0];
      tok_next.p_neg = 1'b1;
    end else begin
      tok_next.p     = dif[62:0];
      tok_next.p_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

/* rtl/sct_round.sv */
// ----------------------------------------------------------------------------
// sct_round
// Final multiply (by x for sine, by one for cosine), rounding to Q1.30 with
// saturation, then the sign.
// ----------------------------------------------------------------------------
module sct_round (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  sct_pkg::tok_t tok_in,
  output sct_pkg::res_t res
);

  localparam logic [63:0] ROUND_HALF = 64'd1 << 29;
  localparam logic [33:0] SAT_Q30    = 34'd1 << 30;

  sct_pkg::tok_t tok_m;
  sct_pkg::mag_t q;
  sct_pkg::mag_t b_op;
  logic [63:0]   rnd;
  logic [30:0]   q_sat;
  logic          vld_a;
  logic          flip_a;
  logic [30:0]   qa;

  assign b_op = tok_in.cos ? sct_pkg::ONE_Q60[62:0] : tok_in.x;

  sct_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tok_in  (tok_in),
    .a       (tok_in.p),
    .b       (b_op),
    .tok_out (tok_m),
    .prod    (q)
  );

  // Round half up and clip to one
  assign rnd   = {1'b0, q} + ROUND_HALF;
  assign q_sat = (rnd[63:30] > SAT_Q30) ? SAT_Q30[30:0] : rnd[60:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      res.vld <= 1'b0;
    end else if (en) begin
      vld_a   <= tok_m.vld;
      res.vld <= vld_a;
    end
  end

  // Apply the combined sign
  always_ff @(posedge clk) begin
    if (en) begin
      qa        <= q_sat;
      flip_a    <= tok_m.p_neg ^ tok_m.neg;
      res.value <= flip_a ? (32'd0 - {1'b0, qa}) : {1'b0, qa};
    end
  end

endmodule

/* rtl/sine_cosine_taylor.sv */
// ----------------------------------------------------------------------------
// sine_cosine_taylor
// Pipelined fixed-point sine/cosine: symmetry reduction, then a truncated
// Taylor series in Horner form, result in Q1.30.
// ----------------------------------------------------------------------------
//
// Channel  Handshake             Fields
// in       in_valid / in_stall   mode (1), angle (32, signed Q6.25)
// out      out_valid / out_stall value (32, signed Q1.30)
//
// One item per cycle sustained while in_stall is low. A result passes through
// 7 reduction stages, nine 3-stage multipliers (the square, seven Horner
// steps with one subtract stage each, the final one), 2 rounding stages
// and the output register.
// Reset clears the valid bits only.
// A stalled result is held in the output register and one more in a skid
// entry; in_stall rises while the skid entry is full and the pipeline holds.
module sine_cosine_taylor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value
);

  localparam logic signed [31:0] VALUE_ONE = 32'sd1073741824;

  sct_pkg::tok_t tok_red;
  sct_pkg::tok_t tok_sq;
  sct_pkg::mag_t sq;
  sct_pkg::tok_t tok_h [sct_pkg::NUM_STEPS+1];
  sct_pkg::res_t res;
  logic          en;
  logic          take;
  logic          skid_full;
  logic [31:0]   skid_value;

  // Whole pipeline advances unless the skid entry is occupied
  assign en       = ~skid_full;
  assign in_stall = skid_full;
  assign take     = out_valid & ~out_stall;

  sct_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .mode    (mode),
    .angle   (angle),
    .tok_out (tok_red)
  );

  sct_mul u_square (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tok_in  (tok_red),
    .a       (tok_red.x),
    .b       (tok_red.x),
    .tok_out (tok_sq),
    .prod    (sq)
  );

  // Seed the accumulator with the top coefficient
  assign tok_h[0] = '{
    vld:   tok_sq.vld,
    cos:   tok_sq.cos,
    neg:   tok_sq.neg,
    x:     tok_sq.x,
    x2:    sq,
    p:     tok_sq.cos ? sct_pkg::INV_FACT[14][62:0] : sct_pkg::INV_FACT[15][62:0],
    p_neg: 1'b0
  };

  for (genvar j = 0; j < sct_pkg::NUM_STEPS; j++) begin : g_step
    sct_horner u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tok_in   (tok_h[j]),
      .coef_cos (sct_pkg::INV_FACT[12-2*j][62:0]),
      .coef_sin (sct_pkg::INV_FACT[13-2*j][62:0]),
      .tok_out  (tok_h[j+1])
    );
  end

  sct_round u_round (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .tok_in (tok_h[sct_pkg::NUM_STEPS]),
    .res    (res)
  );

  // Output register and skid entry: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (en && res.vld) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (take) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register and skid entry: data
  always_ff @(posedge clk) begin
    if (en && res.vld) begin
      if (!out_valid || take) begin
        value <= res.value;
      end else begin
        skid_value <= res.value;
      end
    end else if (take && skid_full) begin
      value <= skid_value;
    end
  end

`include "sine_cosine_taylor_assert.svh"

  `SCT_ASSERT_IMPL(a_skid_behind_out, skid_full, out_valid)
  `SCT_ASSERT_NEXT(a_pipe_holds, !en && res.vld, res.vld && $stable(res.value))
  `SCT_ASSERT_IMPL(a_value_range, out_valid, (value <= VALUE_ONE) && (value >= -VALUE_ONE))

endmodule
